// File: sv/mmjet_pkg.sv
// Shared types and constants for the min/max normalised jet colour map.
// Used by the core, mmjet_sdiv, jet_colour_checker and tb; no dependencies.
package mmjet_pkg;

    localparam int DEF_MAX_POINTS = 64;
    localparam int DEF_VALUE_BITS = 24;
    localparam int THICK_W        = 24;
    localparam int CHAN_W         = 8;

    // width of the divider's quotient and digit registers
    localparam int DIG_W          = CHAN_W;
    localparam int STEP_W         = 4;
    localparam logic [STEP_W-1:0] SEG_STEPS = STEP_W'(3);
    localparam logic [STEP_W-1:0] CH_STEPS  = STEP_W'(8);

    localparam logic [CHAN_W-1:0] CHAN_ZERO = '0;
    localparam logic [CHAN_W-1:0] CHAN_FULL = '1;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_ctl;

endpackage

// File: sv/minmax_normalized_jet_colormap_core.sv
// Min/max normalised jet colour map: buffers a set of thickness items and
// emits one colour item per stored value. Depends on mmjet_pkg, mmjet_sdiv.
//
//   channel  direction  handshake           fields
//   input    in         i_valid / o_stall   i_thickness, i_last_value
//   output   out        o_valid / i_stall   o_red, o_green, o_blue, o_last_point
//
// Input items load one per cycle while collecting; the item flagged last
// starts the colour run, and o_stall stays high until it ends.
// Each colour takes one serial division of 3 steps for the segment and one
// of 8 steps for the channel, then waits while the output is stalled.
// Items beyond MAX_POINTS are dropped. Reset is synchronous and clears
// count, minimum and maximum.
module minmax_normalized_jet_colormap_core #(
    parameter int MAX_POINTS = mmjet_pkg::DEF_MAX_POINTS,
    parameter int VALUE_BITS = mmjet_pkg::DEF_VALUE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [mmjet_pkg::THICK_W-1:0] i_thickness,
    input  logic                          i_last_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [mmjet_pkg::CHAN_W-1:0]  o_red,
    output logic [mmjet_pkg::CHAN_W-1:0]  o_green,
    output logic [mmjet_pkg::CHAN_W-1:0]  o_blue,
    output logic                          o_last_point
);
    import mmjet_pkg::*;

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    typedef enum logic [2:0] {
        S_LOAD, S_SPAN, S_READ, S_INIT, S_SEG, S_PREP, S_CHAN, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        SEG_GREEN_UP   = 3'd0,
        SEG_BLUE_DOWN  = 3'd1,
        SEG_RED_UP     = 3'd2,
        SEG_GREEN_DOWN = 3'd3,
        SEG_END        = 3'd4
    } t_seg;

    t_state                r_state;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_n;
    logic [IDX_W-1:0]      r_idx;
    logic [VALUE_BITS-1:0] r_min;
    logic [VALUE_BITS-1:0] r_max;
    logic [VALUE_BITS-1:0] r_span;
    logic [VALUE_BITS-1:0] r_k;
    t_seg                  r_seg;
    logic                  r_ovalid;
    logic [CHAN_W-1:0]     r_red;
    logic [CHAN_W-1:0]     r_green;
    logic [CHAN_W-1:0]     r_blue;
    logic                  r_olast;

    logic [VALUE_BITS-1:0] r_mem [MAX_POINTS];
    logic [VALUE_BITS-1:0] r_rd;

    logic [VALUE_BITS-1:0]   w_v;
    logic                    w_accept;
    logic                    w_room;
    logic                    w_final;
    logic [VALUE_BITS-1:0]   w_d;
    logic [VALUE_BITS+7:0]   w_prod;
    t_seg                    w_seg;

    t_div_ctl                w_ctl;
    logic [VALUE_BITS-1:0]   w_rem0;
    logic [DIG_W-1:0]        w_low;
    logic                    w_done;
    logic [DIG_W-1:0]        w_quot;
    logic [VALUE_BITS-1:0]   w_rem;

    assign w_v      = VALUE_BITS'(i_thickness);
    assign w_accept = i_valid && (r_state == S_LOAD);
    assign w_room   = r_count < CNT_W'(MAX_POINTS);
    assign w_final  = CNT_W'(r_idx) == (r_n - CNT_W'(1));
    assign w_d      = r_rd - r_min;
    // 255*k as k*256 - k
    assign w_prod   = {r_k, 8'b0} - {8'b0, r_k};
    assign w_seg    = t_seg'(w_quot[2:0]);

    // segment run divides 4d by the span; channel run divides 255*k by it
    always_comb begin
        w_ctl.start = (r_state == S_INIT) || (r_state == S_PREP);
        if (r_state == S_INIT) begin
            w_ctl.steps = SEG_STEPS;
            w_rem0      = w_d >> 1;
            w_low       = {w_d[0], {(DIG_W-1){1'b0}}};
        end else begin
            w_ctl.steps = CH_STEPS;
            w_rem0      = w_prod[VALUE_BITS+7:8];
            w_low       = w_prod[7:0];
        end
    end

    mmjet_sdiv #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_rem0    (w_rem0),
        .i_low     (w_low),
        .i_divisor (r_span),
        .o_done    (w_done),
        .o_quot    (w_quot),
        .o_rem     (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (w_accept && w_room) begin
            r_mem[r_count[IDX_W-1:0]] <= w_v;
        end
        r_rd <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_min    <= '1;
            r_max    <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        if (w_room) begin
                            r_count <= r_count + CNT_W'(1);
                            if (w_v < r_min) begin
                                r_min <= w_v;
                            end
                            if (w_v > r_max) begin
                                r_max <= w_v;
                            end
                        end
                        if (i_last_value) begin
                            r_n     <= w_room ? r_count + CNT_W'(1) : r_count;
                            r_state <= S_SPAN;
                        end
                    end
                end
                S_SPAN: begin
                    r_span  <= r_max - r_min;
                    r_idx   <= '0;
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_INIT;
                end
                S_INIT: begin
                    r_state <= S_SEG;
                end
                S_SEG: begin
                    if (w_done) begin
                        r_seg <= w_seg;
                        case (w_seg) inside
                            SEG_GREEN_UP, SEG_RED_UP:      r_k <= w_rem;
                            SEG_BLUE_DOWN, SEG_GREEN_DOWN: r_k <= r_span - w_rem;
                            default:                       r_k <= '0;
                        endcase
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_state <= S_CHAN;
                end
                S_CHAN: begin
                    if (w_done) begin
                        r_ovalid <= 1'b1;
                        r_olast  <= w_final;
                        if (r_span == '0) begin
                            // flat set: everything is blue
                            r_red   <= CHAN_ZERO;
                            r_green <= CHAN_ZERO;
                            r_blue  <= CHAN_FULL;
                        end else begin
                            case (r_seg)
                                SEG_GREEN_UP: begin
                                    r_red   <= CHAN_ZERO;
                                    r_green <= w_quot;
                                    r_blue  <= CHAN_FULL;
                                end
                                SEG_BLUE_DOWN: begin
                                    r_red   <= CHAN_ZERO;
                                    r_green <= CHAN_FULL;
                                    r_blue  <= w_quot;
                                end
                                SEG_RED_UP: begin
                                    r_red   <= w_quot;
                                    r_green <= CHAN_FULL;
                                    r_blue  <= CHAN_ZERO;
                                end
                                default: begin
                                    r_red   <= CHAN_FULL;
                                    r_green <= w_quot;
                                    r_blue  <= CHAN_ZERO;
                                end
                            endcase
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_ovalid <= 1'b0;
                        if (r_olast) begin
                            r_count <= '0;
                            r_min   <= '1;
                            r_max   <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_idx   <= r_idx + IDX_W'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_stall      = (r_state != S_LOAD);
    assign o_valid      = r_ovalid;
    assign o_red        = r_red;
    assign o_green      = r_green;
    assign o_blue       = r_blue;
    assign o_last_point = r_olast;

endmodule

// File: sv/mmjet_sdiv.sv
// Serial restoring divider: one quotient bit per cycle, the dividend's low
// bits shifted in from a digit register. Depends on mmjet_pkg.
module mmjet_sdiv #(
    parameter int VALUE_BITS = mmjet_pkg::DEF_VALUE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mmjet_pkg::t_div_ctl          i_ctl,
    input  logic [VALUE_BITS-1:0]        i_rem0,
    input  logic [mmjet_pkg::DIG_W-1:0]  i_low,
    input  logic [VALUE_BITS-1:0]        i_divisor,
    output logic                         o_done,
    output logic [mmjet_pkg::DIG_W-1:0]  o_quot,
    output logic [VALUE_BITS-1:0]        o_rem
);
    import mmjet_pkg::*;

    logic [STEP_W-1:0]     r_cnt;
    logic                  r_done;
    logic [VALUE_BITS-1:0] r_rem;
    logic [DIG_W-1:0]      r_low;
    logic [DIG_W-1:0]      r_q;

    logic [VALUE_BITS:0]   w_try;
    logic [VALUE_BITS:0]   w_diff;
    logic                  w_fit;

    // partial remainder stays below the divisor, so the shifted value fits
    assign w_try  = {r_rem, r_low[DIG_W-1]};
    assign w_fit  = w_try >= {1'b0, i_divisor};
    assign w_diff = w_try - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_ctl.start) begin
            r_cnt  <= i_ctl.steps;
            r_done <= 1'b0;
            r_rem  <= i_rem0;
            r_low  <= i_low;
            r_q    <= '0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - STEP_W'(1);
            r_done <= (r_cnt == STEP_W'(1));
            r_rem  <= w_fit ? w_diff[VALUE_BITS-1:0] : w_try[VALUE_BITS-1:0];
            r_low  <= {r_low[DIG_W-2:0], 1'b0};
            r_q    <= {r_q[DIG_W-2:0], w_fit};
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

// File: dv/jet_colour_checker.sv
// Checker for the min/max normalised jet colour map: watches both channels,
// predicts the colour of every stored thickness item and compares field by field.
// Depends on mmjet_pkg.
module jet_colour_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_valid,
    input  logic                          i_item_stall,
    input  logic [mmjet_pkg::THICK_W-1:0] i_thickness,
    input  logic                          i_last_value,
    input  logic                          i_colour_valid,
    input  logic                          i_colour_stall,
    input  logic [mmjet_pkg::CHAN_W-1:0]  i_red,
    input  logic [mmjet_pkg::CHAN_W-1:0]  i_green,
    input  logic [mmjet_pkg::CHAN_W-1:0]  i_blue,
    input  logic                          i_last_point,
    output int                            o_mismatches,
    output int                            o_outstanding,
    output int                            o_items,
    output int                            o_dropped,
    output int                            o_sets,
    output int                            o_colours
);
    import mmjet_pkg::*;

    localparam int MAX_PTS = DEF_MAX_POINTS;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              last;
    } t_colour;

    t_colour            predicted_colours[$];
    t_colour            want;
    t_colour            seen;
    logic [THICK_W-1:0] set_values[MAX_PTS];
    logic [THICK_W-1:0] set_min;
    logic [THICK_W-1:0] set_max;
    int                 set_count;
    int                 mismatch_count = 0;
    int                 item_count = 0;
    int                 drop_count = 0;
    int                 set_total = 0;
    int                 colour_count = 0;
    longint unsigned    span;
    longint unsigned    span_eff;
    longint unsigned    delta;
    longint unsigned    d4;
    longint unsigned    seg;

    task automatic report(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            set_count = 0;
            set_min   = '1;
            set_max   = '0;
            predicted_colours.delete();
        end else begin
            if (i_colour_valid && !i_colour_stall) begin
                colour_count++;
                seen = {i_red, i_green, i_blue, i_last_point};
                if (predicted_colours.size() == 0) begin
                    report($sformatf("colour %0d arrived with none predicted", colour_count));
                end else begin
                    want = predicted_colours.pop_front();
                    if (seen.red != want.red)
                        report($sformatf("colour %0d red: expected %0d, got %0d",
                                         colour_count, want.red, seen.red));
                    if (seen.green != want.green)
                        report($sformatf("colour %0d green: expected %0d, got %0d",
                                         colour_count, want.green, seen.green));
                    if (seen.blue != want.blue)
                        report($sformatf("colour %0d blue: expected %0d, got %0d",
                                         colour_count, want.blue, seen.blue));
                    if (seen.last != want.last)
                        report($sformatf("colour %0d last_point: expected %0d, got %0d",
                                         colour_count, want.last, seen.last));
                end
            end

            if (i_item_valid && !i_item_stall) begin
                item_count++;
                // buffer full: item is dropped and leaves min/max alone
                if (set_count < MAX_PTS) begin
                    set_values[set_count] = i_thickness;
                    set_count++;
                    if (i_thickness < set_min)
                        set_min = i_thickness;
                    if (i_thickness > set_max)
                        set_max = i_thickness;
                end else begin
                    drop_count++;
                end

                if (i_last_value) begin
                    set_total++;
                    span = (set_max >= set_min) ? set_max - set_min : 0;
                    for (int i = 0; i < set_count; i++) begin
                        delta = (set_values[i] >= set_min) ? set_values[i] - set_min : 0;
                        span_eff = span;
                        // zero range: every item maps to the bottom of the ramp
                        if (span == 0) begin
                            span_eff = 1;
                            delta    = 0;
                        end
                        if (delta > span_eff)
                            delta = span_eff;
                        d4  = 4 * delta;
                        seg = d4 / span_eff;
                        case (seg)
                            0: begin
                                want.red   = CHAN_ZERO;
                                want.green = CHAN_W'((d4 * 255) / span_eff);
                                want.blue  = CHAN_FULL;
                            end
                            1: begin
                                want.red   = CHAN_ZERO;
                                want.green = CHAN_FULL;
                                want.blue  = CHAN_W'(((2 * span_eff - d4) * 255) / span_eff);
                            end
                            2: begin
                                want.red   = CHAN_W'(((d4 - 2 * span_eff) * 255) / span_eff);
                                want.green = CHAN_FULL;
                                want.blue  = CHAN_ZERO;
                            end
                            default: begin
                                want.red   = CHAN_FULL;
                                want.green = CHAN_W'(((4 * span_eff - d4) * 255) / span_eff);
                                want.blue  = CHAN_ZERO;
                            end
                        endcase
                        want.last = (i == set_count - 1);
                        predicted_colours = {predicted_colours, want};
                    end
                    set_count = 0;
                    set_min   = '1;
                    set_max   = '0;
                end
            end
        end

        o_mismatches  <= mismatch_count;
        o_outstanding <= predicted_colours.size();
        o_items       <= item_count;
        o_dropped     <= drop_count;
        o_sets        <= set_total;
        o_colours     <= colour_count;
    end

endmodule

// File: dv/tb.sv
// Testbench top for minmax_normalized_jet_colormap_core: drives thickness sets
// with random gaps and output stalls, and gives the verdict from jet_colour_checker.
// Depends on mmjet_pkg, jet_colour_checker and the core.
module tb;

    import mmjet_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT  = 4000;
    localparam int TAIL_CYCLES = 40;
    localparam int ITEM_TARGET = 80;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic [THICK_W-1:0] thickness = '0;
    logic               last_value = 1'b0;
    logic               colour_stall = 1'b0;
    logic               item_stall;
    logic               colour_valid;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic               last_point;

    int mismatches;
    int outstanding;
    int items_seen;
    int dropped;
    int sets_seen;
    int colours_seen;

    logic [THICK_W-1:0] set_vals[$];
    bit                 no_gaps = 1'b0;
    bit                 hold_req = 1'b0;
    bit                 hold_done = 1'b0;

    minmax_normalized_jet_colormap_core i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (item_valid),
        .o_stall      (item_stall),
        .i_thickness  (thickness),
        .i_last_value (last_value),
        .o_valid      (colour_valid),
        .i_stall      (colour_stall),
        .o_red        (red),
        .o_green      (green),
        .o_blue       (blue),
        .o_last_point (last_point)
    );

    jet_colour_checker colour_chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_item_valid   (item_valid),
        .i_item_stall   (item_stall),
        .i_thickness    (thickness),
        .i_last_value   (last_value),
        .i_colour_valid (colour_valid),
        .i_colour_stall (colour_stall),
        .i_red          (red),
        .i_green        (green),
        .i_blue         (blue),
        .i_last_point   (last_point),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding),
        .o_items        (items_seen),
        .o_dropped      (dropped),
        .o_sets         (sets_seen),
        .o_colours      (colours_seen)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // offers set_vals as one set, last flag on the final item
    task automatic send_set();
        int gap;
        int pick;
        foreach (set_vals[k]) begin
            gap  = 0;
            pick = $urandom_range(0, 99);
            if (!no_gaps) begin
                if (pick >= 93)
                    gap = $urandom_range(10, 40);
                else if (pick >= 70)
                    gap = $urandom_range(1, 3);
            end
            if (gap > 0) begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            item_valid <= 1'b1;
            thickness  <= set_vals[k];
            last_value <= (k == set_vals.size() - 1);
            @(posedge clk);
            while (item_stall) @(posedge clk);
        end
    endtask

    // output side: random stall runs, plus one long hold-off once asked
    initial begin
        int pick;
        forever begin
            pick = $urandom_range(0, 99);
            if (hold_req && !hold_done && colour_valid) begin
                hold_done = 1'b1;
                colour_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (pick < 55) begin
                colour_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end else if (pick < 92) begin
                colour_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end else begin
                colour_stall <= 1'b1;
                repeat ($urandom_range(10, 40)) @(posedge clk);
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        @(posedge rst_n);
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (colour_valid && !colour_stall))
                idle = 0;
            else
                idle++;
        end
        $display("timeout: %0d cycles without a handshake, %0d colours outstanding",
                 IDLE_LIMIT, outstanding);
        $display("FAIL");
        $finish;
    end

    initial begin
        int                 sent;
        int                 set_idx;
        int                 len;
        int                 mode;
        int                 pick;
        logic [THICK_W-1:0] base;
        logic [THICK_W-1:0] v;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single item, zero range
        set_vals = {24'h000000};
        send_set();
        set_vals = {24'hFFFFFF};
        no_gaps  = 1'b1;
        send_set();
        // range of four: one item per segment, top one on the red end
        set_vals = {24'd0, 24'd1, 24'd2, 24'd3, 24'd4};
        send_set();
        set_vals = {24'hFFFFFF, 24'h000000, 24'h7FFFFF, 24'h800000, 24'h3FFFFF, 24'hBFFFFF};
        no_gaps  = 1'b0;
        send_set();
        // several equal items
        set_vals = {24'd5, 24'd5, 24'd5};
        send_set();
        set_vals = {24'd10, 24'd3, 24'd7};
        no_gaps  = 1'b1;
        send_set();
        set_vals = {24'h000000, 24'hFFFFFF};
        send_set();

        hold_req <= 1'b1;

        sent    = 0;
        set_idx = 0;
        while (sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            mode = $urandom_range(0, 3);
            if (set_idx == 2) begin
                // overflow: last flag lands on a dropped item
                len  = DEF_MAX_POINTS + 2;
                mode = 0;
            end else if (pick < 70) begin
                len = $urandom_range(1, 6);
            end else if (pick < 95) begin
                len = $urandom_range(7, 16);
            end else begin
                len = $urandom_range(DEF_MAX_POINTS - 4, DEF_MAX_POINTS + 6);
            end
            base = THICK_W'($urandom_range(0, 24'hFFFFF0));
            set_vals.delete();
            repeat (len) begin
                case (mode)
                    0: v = THICK_W'($urandom);
                    1: v = base + THICK_W'($urandom_range(0, 15));
                    2: v = base;
                    default: begin
                        pick = $urandom_range(0, 2);
                        v = (pick == 0) ? '0 : (pick == 1) ? '1 : THICK_W'($urandom);
                    end
                endcase
                set_vals = {set_vals, v};
            end
            no_gaps = ($urandom_range(0, 3) == 0);
            send_set();
            sent += len;
            set_idx++;
        end
        item_valid <= 1'b0;

        do @(posedge clk); while (outstanding != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d sets from %0d thickness items, %0d dropped on a full buffer,",
                 sets_seen, items_seen, dropped);
        $display("with %0d colours checked and %0d mismatches.", colours_seen, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
sv/mmjet_pkg.sv
sv/mmjet_sdiv.sv
sv/minmax_normalized_jet_colormap_core.sv
dv/jet_colour_checker.sv
dv/tb.sv
